// File: rtl/core/linear_interp_resampler_top_assert.svh
// assertion macros shared by the resampler checker
// depends on nothing; included by files that assert
`ifndef LINEAR_INTERP_RESAMPLER_TOP_ASSERT_SVH
`define LINEAR_INTERP_RESAMPLER_TOP_ASSERT_SVH

// same-cycle implication, disabled while reset is high
`define LIRS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is high
`define LIRS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/lirs_pkg.sv
// constants and helpers for the linear interpolation resampler
// no dependencies; imported by the top level and its checker
package lirs_pkg;

  localparam int MAX_BLOCK   = 4096;
  localparam int FRAC_BITS   = 24;
  localparam int SAMPLE_BITS = 16;
  localparam int COUNT_BITS  = 13;
  localparam int BLK_BITS    = $clog2(MAX_BLOCK);
  localparam int STEP_BITS   = 31;
  localparam int PHASE_BITS  = COUNT_BITS + FRAC_BITS;
  localparam int MAX_RESULTS = 64;
  localparam int NUM_BITS    = $clog2(MAX_RESULTS + 1);
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = STEP_BITS;

  localparam logic [CFG_IDX_BITS-1:0] REG_IN_COUNT  = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_OUT_COUNT = CFG_IDX_BITS'(1);
  localparam logic [CFG_IDX_BITS-1:0] REG_STEP      = CFG_IDX_BITS'(2);

  localparam logic [COUNT_BITS-1:0] IN_COUNT_RST  = COUNT_BITS'(192);
  localparam logic [COUNT_BITS-1:0] OUT_COUNT_RST = COUNT_BITS'(2048);
  localparam logic [STEP_BITS-1:0]  STEP_RST      = STEP_BITS'(1572864);

  // clamp a count register to 2..MAX_BLOCK and return it minus one
  function automatic logic [BLK_BITS-1:0] count_m1(input logic [COUNT_BITS-1:0] v);
    logic [BLK_BITS-1:0] r;
    if (v < COUNT_BITS'(2)) begin
      r = BLK_BITS'(1);
    end else if (v > COUNT_BITS'(MAX_BLOCK)) begin
      r = BLK_BITS'(MAX_BLOCK - 1);
    end else begin
      r = BLK_BITS'(v - COUNT_BITS'(1));
    end
    return r;
  endfunction

endpackage

// File: rtl/core/linear_interp_resampler_top.sv
// linear interpolation resampler for complex i/q samples, whole datapath
// depends on lirs_pkg
//
// usage: samples enter on in_valid/in_ready (in_i, in_q), interpolated
// words leave on out_valid/out_ready (out_i, out_q, last). in_count,
// out_count and step_q24 are set through cfg_we/cfg_index/cfg_data.
// an accepted sample produces zero or more words; last marks the final
// word caused by that sample. the very first sample after reset (and no
// other) is only stored.
// timing: one shared 17x25 multiplier serves i then q, so each word passes
// through check, multiply i, multiply q and finish; a word is loaded into
// the output register at the next check. in_ready stays low while an item
// is being worked; words beyond 64 for one item are consumed and dropped.
// in_ready is high only when idle.
// reset: synchronous, clears the block state and loads the default rates
// (192 in, 2048 out, step 0.09375). a stalled receiver freezes the sequencer
// at its next hand-over of a word; the output register holds its word.
module linear_interp_resampler_top
  import lirs_pkg::*;
(
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [CFG_IDX_BITS-1:0]         cfg_index,
  input  logic [CFG_DATA_BITS-1:0]        cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [SAMPLE_BITS-1:0]   in_i,
  input  logic signed [SAMPLE_BITS-1:0]   in_q,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [SAMPLE_BITS-1:0]   out_i,
  output logic signed [SAMPLE_BITS-1:0]   out_q,
  output logic                            last
);

  localparam int DIFF_BITS = SAMPLE_BITS + 1;
  localparam int PROD_BITS = DIFF_BITS + FRAC_BITS + 1;
  localparam int RND_BITS  = PROD_BITS - FRAC_BITS;

  // sequencer states, one-hot
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CHECK = 5'b00010,
    S_MUL_I = 5'b00100,
    S_MUL_Q = 5'b01000,
    S_FIN   = 5'b10000
  } state_t;

  state_t state;

  // configuration
  logic [COUNT_BITS-1:0] in_count;
  logic [COUNT_BITS-1:0] out_count;
  logic [STEP_BITS-1:0]  step_q24;

  // block state
  logic signed [SAMPLE_BITS-1:0] prev_i, prev_q;
  logic signed [SAMPLE_BITS-1:0] cur_i, cur_q;
  logic [COUNT_BITS-1:0]         position;
  logic [COUNT_BITS-1:0]         out_index;
  logic [PHASE_BITS-1:0]         phase;
  logic                          blk_end;
  logic [NUM_BITS-1:0]           num;

  // pending word, held until we know whether it is the last one
  logic                          hold_valid;
  logic signed [SAMPLE_BITS-1:0] hold_i, hold_q;

  // shared multiplier
  logic signed [PROD_BITS-1:0]   prod;
  logic signed [DIFF_BITS-1:0]   diff_i, diff_q, mul_a;
  logic signed [FRAC_BITS:0]     mul_f;
  logic signed [PROD_BITS-1:0]   prod_rnd;
  logic signed [SAMPLE_BITS-1:0] interp_val;
  logic signed [SAMPLE_BITS-1:0] prev_sel, cur_sel;

  logic [BLK_BITS-1:0]   total;
  logic [BLK_BITS-1:0]   in_m1;
  logic [COUNT_BITS-1:0] base;
  logic                  past_end;
  logic                  go;
  logic                  emit_busy;
  logic                  load_out;
  logic                  load_last;
  logic [COUNT_BITS-1:0] index_inc;
  logic [PHASE_BITS:0]   phase_sum;
  logic [PHASE_BITS-1:0] phase_inc;

  assign total    = count_m1(out_count);
  assign in_m1    = count_m1(in_count);
  assign base     = phase[PHASE_BITS-1:FRAC_BITS];
  // outputs at or past the current sample take the sample itself
  assign past_end = (base >= position);
  assign go       = (out_index < {1'b0, total}) && (!past_end || blk_end);

  assign index_inc = out_index + COUNT_BITS'(1);
  assign phase_sum = {1'b0, phase} + (PHASE_BITS + 1)'(step_q24);
  assign phase_inc = phase_sum[PHASE_BITS] ? '1 : phase_sum[PHASE_BITS-1:0];

  assign emit_busy = hold_valid && out_valid && !out_ready;
  assign load_out  = (state == S_CHECK) && hold_valid && !emit_busy;
  // the 64th word of an item is always its last
  assign load_last = !go || (num == NUM_BITS'(MAX_RESULTS));

  assign in_ready = (state == S_IDLE);

  // interpolation: prev + round((cur - prev) * frac), ties upward
  assign diff_i = DIFF_BITS'(cur_i) - DIFF_BITS'(prev_i);
  assign diff_q = DIFF_BITS'(cur_q) - DIFF_BITS'(prev_q);
  assign mul_a  = (state == S_MUL_I) ? diff_i : diff_q;
  assign mul_f  = {1'b0, phase[FRAC_BITS-1:0]};
  assign prod_rnd = prod + (PROD_BITS'(1) <<< (FRAC_BITS - 1));
  assign prev_sel = (state == S_MUL_Q) ? prev_i : prev_q;
  assign cur_sel  = (state == S_MUL_Q) ? cur_i : cur_q;
  assign interp_val = past_end ? cur_sel
                    : SAMPLE_BITS'(RND_BITS'(prev_sel) + prod_rnd[PROD_BITS-1:FRAC_BITS]);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      in_count  <= IN_COUNT_RST;
      out_count <= OUT_COUNT_RST;
      step_q24  <= STEP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IN_COUNT:  in_count  <= cfg_data[COUNT_BITS-1:0];
        REG_OUT_COUNT: out_count <= cfg_data[COUNT_BITS-1:0];
        REG_STEP:      step_q24  <= cfg_data[STEP_BITS-1:0];
        default: ;
      endcase
    end
  end

  // sequencer and block state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      prev_i     <= '0;
      prev_q     <= '0;
      position   <= '0;
      out_index  <= '0;
      phase      <= '0;
      blk_end    <= 1'b0;
      num        <= '0;
      hold_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (position == '0) begin
              // first sample after reset only opens the block
              prev_i    <= in_i;
              prev_q    <= in_q;
              position  <= COUNT_BITS'(1);
              out_index <= '0;
              phase     <= '0;
            end else begin
              blk_end <= (position >= {1'b0, in_m1});
              num     <= '0;
              state   <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          if (!emit_busy) begin
            hold_valid <= 1'b0;
            if (go) begin
              if (num == NUM_BITS'(MAX_RESULTS)) begin
                // over the per-item limit: consume and drop
                out_index <= index_inc;
                phase     <= phase_inc;
              end else begin
                state <= S_MUL_I;
              end
            end else begin
              prev_i <= cur_i;
              prev_q <= cur_q;
              if (blk_end) begin
                position  <= COUNT_BITS'(1);
                out_index <= '0;
                phase     <= '0;
              end else begin
                position <= position + COUNT_BITS'(1);
              end
              state <= S_IDLE;
            end
          end
        end
        S_MUL_I: begin
          state <= S_MUL_Q;
        end
        S_MUL_Q: begin
          state <= S_FIN;
        end
        S_FIN: begin
          hold_valid <= 1'b1;
          num        <= num + NUM_BITS'(1);
          out_index  <= index_inc;
          phase      <= phase_inc;
          state      <= S_CHECK;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cur_i <= in_i;
      cur_q <= in_q;
    end
    if (state == S_MUL_I || state == S_MUL_Q) begin
      prod <= mul_a * mul_f;
    end
    if (state == S_MUL_Q) begin
      hold_i <= interp_val;
    end
    if (state == S_FIN) begin
      hold_q <= interp_val;
    end
    if (load_out) begin
      out_i <= hold_i;
      out_q <= hold_q;
      last  <= load_last;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// File: rtl/core/lirs_checker.sv
// port-level checker for the linear interpolation resampler, with its bind
// depends on lirs_pkg and linear_interp_resampler_top_assert.svh
`include "linear_interp_resampler_top_assert.svh"

module lirs_checker
  import lirs_pkg::*;
(
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [SAMPLE_BITS-1:0] out_i,
  input logic signed [SAMPLE_BITS-1:0] out_q,
  input logic                          last
);

  // a stalled word holds
  `LIRS_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_i) && $stable(out_q) && $stable(last), "output word changed while stalled")

  // while a non-final word waits the item is still in progress
  `LIRS_ASSERT_IMP(a_busy_mid_item, clk, rst, out_valid && !last, !in_ready, "new sample taken before the item ended")

  // taking a sample never loads a word in the same cycle
  `LIRS_ASSERT_NXT(a_no_word_on_take, clk, rst, in_valid && in_ready, !$rose(out_valid), "word appeared on sample acceptance")

endmodule

bind linear_interp_resampler_top lirs_checker u_lirs_checker (.*);
